### rtl/core/pic_pkg.sv
package pic_pkg;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_IRQ   = 2'd2,
		ACT_ACK   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		OP_ROT_OFF  = 3'd0,
		OP_EOI      = 3'd1,
		OP_NOP      = 3'd2,
		OP_SEOI     = 3'd3,
		OP_ROT_ON   = 3'd4,
		OP_ROT_EOI  = 3'd5,
		OP_SET_PRIO = 3'd6,
		OP_ROT_SEOI = 3'd7
	} ocw2_op_t;

	localparam logic       PORT_CMD  = 1'b0;
	localparam logic       PORT_MASK = 1'b1;

	localparam logic [1:0] RSEL_IRR  = 2'b10;
	localparam logic [1:0] RSEL_ISR  = 2'b11;
	localparam logic [1:0] SMM_CLR   = 2'b10;
	localparam logic [1:0] SMM_SET   = 2'b11;

	localparam logic [7:0] VEC_BASE_MASK = 8'hF8;
	localparam logic [7:0] READ_NONE     = 8'hFF;

	localparam logic [1:0] STEP_IDLE = 2'd0;
	localparam logic [1:0] STEP_ICW4 = 2'd3;

	typedef struct packed {
		logic       found;
		logic [2:0] line;
	} prio_t;

endpackage

### rtl/core/pic_in_if.sv
interface pic_in_if;
	logic              valid;
	logic              ready;
	pic_pkg::action_t  action;
	logic              port_select;
	logic [7:0]        write_data;
	logic [2:0]        irq_line;
	logic              irq_level;

	modport source (output valid, action, port_select, write_data, irq_line, irq_level,
		input ready);
	modport sink (input valid, action, port_select, write_data, irq_line, irq_level,
		output ready);
endinterface

### rtl/core/pic_out_if.sv
interface pic_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       init_done;
	logic       ack_taken;
	logic [7:0] vector;
	logic       int_pending;
	logic [2:0] pending_line;

	modport source (output valid, read_data, init_done, ack_taken, vector, int_pending,
		pending_line, input ready);
	modport sink (input valid, read_data, init_done, ack_taken, vector, int_pending,
		pending_line, output ready);
endinterface

### rtl/core/pic_prio.sv
module pic_prio (
	input  logic [7:0]     bits,
	input  logic [2:0]     top,
	output pic_pkg::prio_t res
);
	logic [15:0] dbl;
	logic [7:0]  rot;
	logic [2:0]  idx;
	logic        hit;

	// rotate so the top-priority line sits at bit 0
	assign dbl = {bits, bits} >> top;
	assign rot = dbl[7:0];

	always_comb begin
		idx = 3'd0;
		hit = 1'b0;
		for (int k = 7; k >= 0; k--) begin
			if (rot[k]) begin
				idx = 3'(k);
				hit = 1'b1;
			end
		end
	end

	assign res.found = hit;
	assign res.line  = hit ? idx + top : 3'd0;
endmodule

### rtl/core/programmable_interrupt_controller.sv
// channel  modport  payload                                              handshake
// req      sink     action, port_select, write_data, irq_line, irq_level  valid/ready
// rsp      source   read_data, init_done, ack_taken, vector,              valid/ready
//                   int_pending, pending_line
//
// one word in per cycle unless the result side stalls, its result passing an input and then a result register
// the rotating priority encode of the request, in-service and mask bits sets the logic depth
// reset clears all controller state and both pipeline valids
// a stalled result register holds the input register, which then holds req.ready low
module programmable_interrupt_controller (
	input logic           clk,
	input logic           arst_n,
	pic_in_if.sink        req,
	pic_out_if.source     rsp
);
	logic             valid_s1;
	pic_pkg::action_t act_s1;
	logic             port_s1;
	logic [7:0]       data_s1;
	logic [2:0]       line_s1;
	logic             lvl_s1;

	logic             valid_s2;
	logic [7:0]       rd_s2;
	logic             done_s2;
	logic             taken_s2;
	logic [7:0]       vec_s2;
	logic             pend_s2;
	logic [2:0]       pline_s2;

	logic [7:0] irr_q, isr_q, imr_q, ocw2_q, ocw3_q;
	logic [7:0] icw_q [4];
	logic [1:0] step_q;
	logic [2:0] top_q;
	logic       smm_q, arot_q;

	logic [7:0] irr_d, isr_d, imr_d, ocw2_d, ocw3_d;
	logic [7:0] icw_d [4];
	logic [1:0] step_d;
	logic [2:0] top_d;
	logic       smm_d, arot_d;

	logic [7:0] rd_d, vec_d;
	logic       done_d, taken_d;
	logic       adv;

	pic_pkg::prio_t svc_res, ack_res, post_res;

	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	pic_prio u_svc  (.bits(isr_q), .top(top_q), .res(svc_res));
	pic_prio u_ack  (.bits(irr_q & ~isr_q & ~imr_q), .top(top_q), .res(ack_res));
	pic_prio u_post (.bits(irr_d & ~isr_d & ~imr_d), .top(top_d), .res(post_res));

	always_comb begin
		irr_d   = irr_q;
		isr_d   = isr_q;
		imr_d   = imr_q;
		ocw2_d  = ocw2_q;
		ocw3_d  = ocw3_q;
		icw_d   = icw_q;
		step_d  = step_q;
		top_d   = top_q;
		smm_d   = smm_q;
		arot_d  = arot_q;
		rd_d    = 8'd0;
		vec_d   = 8'd0;
		done_d  = 1'b0;
		taken_d = 1'b0;
		unique case (act_s1)
			pic_pkg::ACT_WRITE: begin
				if (port_s1 == pic_pkg::PORT_CMD) begin
					if (data_s1[4]) begin
						icw_d[0] = data_s1;
						step_d   = 2'd1;
					end else if (!data_s1[3]) begin
						ocw2_d = data_s1;
						unique case (pic_pkg::ocw2_op_t'(data_s1[7:5]))
							pic_pkg::OP_ROT_OFF: arot_d = 1'b0;
							pic_pkg::OP_EOI: begin
								if (svc_res.found)
									isr_d = isr_q & ~(8'd1 << svc_res.line);
							end
							pic_pkg::OP_NOP: ;
							pic_pkg::OP_SEOI: isr_d = isr_q & ~(8'd1 << data_s1[2:0]);
							pic_pkg::OP_ROT_ON: arot_d = 1'b1;
							pic_pkg::OP_ROT_EOI: begin
								if (svc_res.found) begin
									isr_d = isr_q & ~(8'd1 << svc_res.line);
									top_d = svc_res.line + 3'd1;
								end
							end
							pic_pkg::OP_SET_PRIO: top_d = data_s1[2:0] + 3'd1;
							pic_pkg::OP_ROT_SEOI: begin
								isr_d = isr_q & ~(8'd1 << data_s1[2:0]);
								top_d = data_s1[2:0] + 3'd1;
							end
							default: ;
						endcase
					end else begin
						ocw3_d = data_s1;
						if (data_s1[6:5] == pic_pkg::SMM_CLR)
							smm_d = 1'b0;
						else if (data_s1[6:5] == pic_pkg::SMM_SET)
							smm_d = 1'b1;
					end
				end else if (step_q == pic_pkg::STEP_IDLE) begin
					imr_d = data_s1;
				end else begin
					icw_d[step_q] = data_s1;
					step_d        = step_q + 2'd1;
					done_d        = (step_q == pic_pkg::STEP_ICW4);
				end
			end
			pic_pkg::ACT_READ: begin
				if (port_s1 == pic_pkg::PORT_MASK)
					rd_d = imr_q;
				else if (ocw3_q[1:0] == pic_pkg::RSEL_IRR)
					rd_d = irr_q;
				else if (ocw3_q[1:0] == pic_pkg::RSEL_ISR)
					rd_d = isr_q;
				else
					rd_d = pic_pkg::READ_NONE;
			end
			pic_pkg::ACT_IRQ: begin
				if (lvl_s1)
					irr_d = irr_q | (8'd1 << line_s1);
				else
					irr_d = irr_q & ~(8'd1 << line_s1);
			end
			pic_pkg::ACT_ACK: begin
				if (ack_res.found) begin
					isr_d   = isr_q | (8'd1 << ack_res.line);
					vec_d   = (icw_q[1] & pic_pkg::VEC_BASE_MASK) | {5'd0, ack_res.line};
					taken_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			irr_q    <= 8'd0;
			isr_q    <= 8'd0;
			imr_q    <= 8'd0;
			ocw2_q   <= 8'd0;
			ocw3_q   <= 8'd0;
			icw_q    <= '{default: 8'd0};
			step_q   <= pic_pkg::STEP_IDLE;
			top_q    <= 3'd0;
			smm_q    <= 1'b0;
			arot_q   <= 1'b0;
		end else begin
			if (req.valid && req.ready)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= 1'b1;
			else if (rsp.ready)
				valid_s2 <= 1'b0;
			if (adv) begin
				irr_q  <= irr_d;
				isr_q  <= isr_d;
				imr_q  <= imr_d;
				ocw2_q <= ocw2_d;
				ocw3_q <= ocw3_d;
				icw_q  <= icw_d;
				step_q <= step_d;
				top_q  <= top_d;
				smm_q  <= smm_d;
				arot_q <= arot_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_s1  <= req.action;
			port_s1 <= req.port_select;
			data_s1 <= req.write_data;
			line_s1 <= req.irq_line;
			lvl_s1  <= req.irq_level;
		end
		if (adv) begin
			rd_s2    <= rd_d;
			done_s2  <= done_d;
			taken_s2 <= taken_d;
			vec_s2   <= vec_d;
			pend_s2  <= post_res.found;
			pline_s2 <= post_res.line;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.read_data    = rd_s2;
	assign rsp.init_done    = done_s2;
	assign rsp.ack_taken    = taken_s2;
	assign rsp.vector       = vec_s2;
	assign rsp.int_pending  = pend_s2;
	assign rsp.pending_line = pline_s2;

	a_ack_sets_isr: assert property (@(posedge clk) disable iff (!arst_n)
		adv && act_s1 == pic_pkg::ACT_ACK && ack_res.found |=> isr_q[$past(ack_res.line)])
		else $error("acknowledged line not in service");

	a_init_keeps_mask: assert property (@(posedge clk) disable iff (!arst_n)
		adv && act_s1 == pic_pkg::ACT_WRITE && port_s1 == pic_pkg::PORT_MASK
		&& step_q != pic_pkg::STEP_IDLE |=> $stable(imr_q))
		else $error("mask changed during init sequence");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(data_s1) && $stable(act_s1))
		else $error("input stage overwritten while stalled");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && done_s2 |-> step_q == pic_pkg::STEP_IDLE)
		else $error("init done reported with init still open");
endmodule

### bench/tb_programmable_interrupt_controller.sv
module tb_programmable_interrupt_controller;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		pic_pkg::action_t action;
		logic             port_select;
		logic [7:0]       write_data;
		logic [2:0]       irq_line;
		logic             irq_level;
	} pic_word_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       init_done;
		logic       ack_taken;
		logic [7:0] vector;
		logic       int_pending;
		logic [2:0] pending_line;
	} pic_result_t;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_WORDS = 1700;
	localparam int PHASE_WORDS  = 150;
	localparam int HOLD_CYCLES  = 80;
	localparam int HOLD_AFTER   = 1000;

	logic clk;
	logic arst_n;

	pic_in_if  req ();
	pic_out_if rsp ();

	programmable_interrupt_controller i_dut (
		.clk,
		.arst_n,
		.req (req),
		.rsp (rsp)
	);

	pic_word_t   word_q [$];
	pic_result_t result_q [$];
	int unsigned total_words;
	int unsigned accepted;
	int unsigned results_taken;
	int unsigned errors;
	int unsigned cycles;
	int unsigned hold_left;
	bit          hold_done;
	pic_result_t want_r;

	// controller state as predicted
	logic [7:0] irr_bits;
	logic [7:0] isr_bits;
	logic [7:0] imr_bits;
	logic [7:0] icw [4];
	logic [7:0] ocw2_word;
	logic [7:0] ocw3_word;
	logic [1:0] init_step;
	logic [2:0] top_line;
	logic       special_mask;
	logic       auto_rotate;

	function automatic pic_pkg::prio_t highest_line(logic [7:0] bits);
		pic_pkg::prio_t p;
		logic [2:0]     ln;
		p = '0;
		for (int k = 7; k >= 0; k--) begin
			ln = top_line + 3'(k);
			if (bits[ln]) begin
				p.found = 1'b1;
				p.line  = ln;
			end
		end
		return p;
	endfunction

	function automatic logic [7:0] pending_bits();
		return irr_bits & ~isr_bits & ~imr_bits;
	endfunction

	function automatic void command_write(logic [7:0] d);
		pic_pkg::prio_t    hi;
		pic_pkg::ocw2_op_t op;
		hi = highest_line(isr_bits);
		op = pic_pkg::ocw2_op_t'(d[7:5]);
		if (d[4]) begin
			icw[0]    = d;
			init_step = 2'd1;
		end else if (!d[3]) begin
			ocw2_word = d;
			case (op)
				pic_pkg::OP_ROT_OFF: auto_rotate = 1'b0;
				pic_pkg::OP_EOI: begin
					if (hi.found)
						isr_bits[hi.line] = 1'b0;
				end
				pic_pkg::OP_SEOI: isr_bits[d[2:0]] = 1'b0;
				pic_pkg::OP_ROT_ON: auto_rotate = 1'b1;
				pic_pkg::OP_ROT_EOI: begin
					if (hi.found) begin
						isr_bits[hi.line] = 1'b0;
						top_line = hi.line + 3'd1;
					end
				end
				pic_pkg::OP_SET_PRIO: top_line = d[2:0] + 3'd1;
				pic_pkg::OP_ROT_SEOI: begin
					isr_bits[d[2:0]] = 1'b0;
					top_line = d[2:0] + 3'd1;
				end
				default: ;
			endcase
		end else begin
			ocw3_word = d;
			if (d[6:5] == pic_pkg::SMM_CLR)
				special_mask = 1'b0;
			else if (d[6:5] == pic_pkg::SMM_SET)
				special_mask = 1'b1;
		end
	endfunction

	function automatic pic_result_t predict_result(pic_word_t w);
		pic_result_t    r;
		pic_pkg::prio_t p;
		r = '0;
		case (w.action)
			pic_pkg::ACT_WRITE: begin
				if (w.port_select == pic_pkg::PORT_CMD) begin
					command_write(w.write_data);
				end else if (init_step == pic_pkg::STEP_IDLE) begin
					imr_bits = w.write_data;
				end else begin
					icw[init_step] = w.write_data;
					r.init_done = (init_step == pic_pkg::STEP_ICW4);
					init_step = init_step + 2'd1;
				end
			end
			pic_pkg::ACT_READ: begin
				if (w.port_select == pic_pkg::PORT_MASK)
					r.read_data = imr_bits;
				else if (ocw3_word[1:0] == pic_pkg::RSEL_IRR)
					r.read_data = irr_bits;
				else if (ocw3_word[1:0] == pic_pkg::RSEL_ISR)
					r.read_data = isr_bits;
				else
					r.read_data = pic_pkg::READ_NONE;
			end
			pic_pkg::ACT_IRQ: irr_bits[w.irq_line] = w.irq_level;
			default: begin
				p = highest_line(pending_bits());
				if (p.found) begin
					isr_bits[p.line] = 1'b1;
					r.vector    = (icw[1] & pic_pkg::VEC_BASE_MASK) | {5'd0, p.line};
					r.ack_taken = 1'b1;
				end
			end
		endcase
		p = highest_line(pending_bits());
		r.int_pending  = p.found;
		r.pending_line = p.found ? p.line : 3'd0;
		return r;
	endfunction

	function automatic int sender_idle_pct(int unsigned n);
		case ((n / PHASE_WORDS) % 4)
			1: return 56;
			3: return 18;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct(int unsigned n);
		case ((n / PHASE_WORDS) % 4)
			2: return 56;
			3: return 18;
			default: return 0;
		endcase
	endfunction

	task automatic add_word(pic_pkg::action_t a, logic port, logic [7:0] d, logic [2:0] ln,
		logic lvl);
		pic_word_t w;
		w.action      = a;
		w.port_select = port;
		w.write_data  = d;
		w.irq_line    = ln;
		w.irq_level   = lvl;
		word_q = {word_q, w};
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	task automatic build_random_words();
		pic_word_t w;
		int        roll;
		int        n;
		n = 0;
		while (n < RANDOM_WORDS) begin
			roll          = $urandom_range(99);
			w.action      = pic_pkg::action_t'($urandom_range(3));
			w.port_select = 1'($urandom_range(1));
			w.write_data  = 8'($urandom_range(255));
			w.irq_line    = 3'($urandom_range(7));
			w.irq_level   = 1'($urandom_range(1));
			if (roll < 4) begin
				// full init sequence with random content
				add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_CMD, w.write_data | 8'h10,
					w.irq_line, w.irq_level);
				for (int i = 0; i < 3; i++)
					add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_MASK, 8'($urandom_range(255)),
						3'($urandom_range(7)), 1'($urandom_range(1)));
				n += 4;
				continue;
			end else if (roll < 24) begin
				w.action      = pic_pkg::ACT_WRITE;
				w.port_select = pic_pkg::PORT_CMD;
				w.write_data  = {3'($urandom_range(7)), 2'b00, 3'($urandom_range(7))};
			end else if (roll < 32) begin
				w.action      = pic_pkg::ACT_WRITE;
				w.port_select = pic_pkg::PORT_CMD;
				w.write_data  = {1'($urandom_range(1)), 2'($urandom_range(3)), 2'b01,
					3'($urandom_range(7))};
			end else if (roll < 40) begin
				w.action      = pic_pkg::ACT_WRITE;
				w.port_select = pic_pkg::PORT_MASK;
				w.write_data  = 8'($urandom_range(255)) & 8'($urandom_range(255));
			end else if (roll < 52) begin
				w.action = pic_pkg::ACT_READ;
			end else if (roll < 74) begin
				w.action    = pic_pkg::ACT_IRQ;
				w.irq_level = ($urandom_range(9) < 6);
			end else if (roll < 94) begin
				w.action = pic_pkg::ACT_ACK;
			end
			word_q = {word_q, w};
			n++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.action      = pic_pkg::ACT_WRITE;
		req.port_select = 1'b0;
		req.write_data  = 8'd0;
		req.irq_line    = 3'd0;
		req.irq_level   = 1'b0;
		rsp.ready       = 1'b0;
		accepted        = 0;
		results_taken   = 0;
		errors          = 0;
		cycles          = 0;
		hold_left       = 0;
		hold_done       = 1'b0;
		irr_bits        = '0;
		isr_bits        = '0;
		imr_bits        = '0;
		for (int i = 0; i < 4; i++)
			icw[i] = '0;
		ocw2_word       = '0;
		ocw3_word       = '0;
		init_step       = pic_pkg::STEP_IDLE;
		top_line        = '0;
		special_mask    = 1'b0;
		auto_rotate     = 1'b0;

		// acknowledge and eoi with nothing pending or in service
		add_word(pic_pkg::ACT_ACK, pic_pkg::PORT_MASK, 8'hFF, 3'd7, 1'b1);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_CMD, {pic_pkg::OP_EOI, 5'd0}, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_CMD, {pic_pkg::OP_ROT_EOI, 5'd0}, 3'd0,
			1'b0);
		// init sequence
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_CMD, 8'h13, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_MASK, 8'hFF, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_MASK, 8'h00, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_MASK, 8'h01, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_READ, pic_pkg::PORT_CMD, 8'h00, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_IRQ, pic_pkg::PORT_CMD, 8'h00, 3'd7, 1'b1);
		add_word(pic_pkg::ACT_IRQ, pic_pkg::PORT_MASK, 8'h00, 3'd0, 1'b1);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_CMD,
			{1'b0, 2'b00, 2'b01, 1'b0, pic_pkg::RSEL_IRR}, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_READ, pic_pkg::PORT_CMD, 8'h00, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_ACK, pic_pkg::PORT_CMD, 8'h00, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_CMD,
			{1'b0, pic_pkg::SMM_SET, 2'b01, 1'b0, pic_pkg::RSEL_ISR}, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_READ, pic_pkg::PORT_CMD, 8'h00, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_ACK, pic_pkg::PORT_CMD, 8'h00, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_CMD, {pic_pkg::OP_SEOI, 5'd0}, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_CMD, {pic_pkg::OP_ROT_EOI, 5'd0}, 3'd0,
			1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_CMD, {pic_pkg::OP_SET_PRIO, 5'd3}, 3'd0,
			1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_CMD, {pic_pkg::OP_ROT_SEOI, 5'd5}, 3'd0,
			1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_CMD, {pic_pkg::OP_ROT_ON, 5'd0}, 3'd0,
			1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_CMD, {pic_pkg::OP_ROT_OFF, 5'd0}, 3'd0,
			1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_CMD, {pic_pkg::OP_NOP, 5'd0}, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_MASK, 8'hFF, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_READ, pic_pkg::PORT_MASK, 8'h00, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_ACK, pic_pkg::PORT_CMD, 8'h00, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_CMD,
			{1'b0, pic_pkg::SMM_CLR, 2'b01, 1'b0, 2'b00}, 3'd0, 1'b0);
		add_word(pic_pkg::ACT_IRQ, pic_pkg::PORT_CMD, 8'h00, 3'd7, 1'b0);
		add_word(pic_pkg::ACT_WRITE, pic_pkg::PORT_MASK, 8'h00, 3'd0, 1'b0);
		build_random_words();
		total_words = word_q.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		wait (accepted == total_words && result_q.size() == 0);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("PASS programmable_interrupt_controller");
		else
			$display("FAIL programmable_interrupt_controller");
		$finish;
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				result_q = {result_q, predict_result(word_q.pop_front())};
				accepted++;
			end
			if (!req.valid || req.ready) begin
				if (word_q.size() > 0 && $urandom_range(99) >= sender_idle_pct(accepted)) begin
					req.valid       <= 1'b1;
					req.action      <= word_q[0].action;
					req.port_select <= word_q[0].port_select;
					req.write_data  <= word_q[0].write_data;
					req.irq_line    <= word_q[0].irq_line;
					req.irq_level   <= word_q[0].irq_level;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// receiver, with one long hold-off to back up the pipeline
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready)
				results_taken++;
			if (!hold_done && results_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= receiver_stall_pct(results_taken));
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (result_q.size() == 0) begin
				$error("result word with no expectation waiting");
				errors++;
			end else begin
				want_r = result_q.pop_front();
				check_field("read_data", want_r.read_data, rsp.read_data);
				check_field("init_done", want_r.init_done, rsp.init_done);
				check_field("ack_taken", want_r.ack_taken, rsp.ack_taken);
				check_field("vector", want_r.vector, rsp.vector);
				check_field("int_pending", want_r.int_pending, rsp.int_pending);
				check_field("pending_line", want_r.pending_line, rsp.pending_line);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL programmable_interrupt_controller");
			$finish;
		end
	end

endmodule
